>>> design/assert_macros.svh
// Assertion macros used by the top level of the minimizer block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/ckm_pkg.sv
// Shared types and constants of the canonical k-mer minimizer
`timescale 1ns / 1ps
`default_nettype none
package ckm_pkg;

	// Widths fixed by the register map and the input field
	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int BASE_W      = 3;
	localparam int DEF_MAX_SPAN = 31;

	// Base code N; codes from here up restart the window
	localparam logic [BASE_W-1:0] BASE_N = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTH   = 2'd2;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Register stages of one hash lane
	localparam int HASH_STAGES = 4;

	// Control part of one request handed from front to back
	typedef struct packed {
		logic             rev;
		logic             both;
		logic [CFG_W-1:0] span;
		logic [CFG_W-1:0] weight;
	} job_ctrl_t;

endpackage
`default_nettype wire

>>> design/ckm_front.sv
// Front end: configuration registers, rolling window and request classification
`timescale 1ns / 1ps
`default_nettype none
module ckm_front #(
	parameter int MAX_SPAN = ckm_pkg::DEF_MAX_SPAN,
	localparam int KW = 2 * MAX_SPAN
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [ckm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ckm_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       base_valid,
	output logic                            base_ready,
	input  wire logic [ckm_pkg::BASE_W-1:0] base_code,
	input  wire logic                       job_full,
	output logic                            job_push,
	output ckm_pkg::job_ctrl_t              job_ctrl,
	output logic [KW-1:0]                   job_fwd,
	output logic [KW-1:0]                   job_rcv
);
	import ckm_pkg::*;

	localparam int SH_W  = $clog2(KW);
	localparam int BAL_W = 7;
	localparam int MIN_SPAN = 9;
	localparam logic [CFG_W-1:0] RST_SPAN   = 5'd25;
	localparam logic [CFG_W-1:0] RST_WEIGHT = 5'd17;
	localparam logic signed [BAL_W-1:0] STEP_AC   = 7'sd1;
	localparam logic signed [BAL_W-1:0] STEP_GT   = -7'sd1;
	localparam logic signed [BAL_W-1:0] STEP_NONE = 7'sd0;
	localparam logic signed [BAL_W-1:0] REV_LIMIT = 7'sd4;

	// A and C push the balance up, G and T push it down
	function automatic logic signed [BAL_W-1:0] strand_step(input logic [1:0] b);
		return b[1] ? STEP_GT : STEP_AC;
	endfunction

	logic [CFG_W-1:0]        kmer_span_q;
	logic [CFG_W-1:0]        sub_weight_q;
	logic                    both_strands_q;
	logic [KW-1:0]           fwd_q;
	logic [KW-1:0]           rcv_q;
	logic signed [BAL_W-1:0] bal_q;
	logic [CFG_W-1:0]        fill_q;

	logic [CFG_W-1:0]        span_e;
	logic [CFG_W-1:0]        weight_e;
	logic [KW-1:0]           kmask;
	logic [SH_W-1:0]         top_sh;
	logic [KW-1:0]           fwd_sh;
	logic [KW-1:0]           fwd_d;
	logic [KW-1:0]           rcv_d;
	logic [1:0]              b;
	logic [1:0]              leaving;
	logic                    accept;
	logic                    clean;
	logic                    full_now;
	logic signed [BAL_W-1:0] bal_d;
	logic [CFG_W-1:0]        fill_d;

	// Effective span and weight after clamping
	always_comb begin
		span_e = kmer_span_q;
		if (span_e < CFG_W'(MIN_SPAN)) span_e = CFG_W'(MIN_SPAN);
		if (span_e > CFG_W'(MAX_SPAN)) span_e = CFG_W'(MAX_SPAN);
		weight_e = sub_weight_q;
		if (weight_e == '0) weight_e = CFG_W'(1);
		if (weight_e > span_e) weight_e = span_e;
	end

	// Window mask, 2*span low bits
	always_comb begin
		for (int j = 0; j < KW; j++) kmask[j] = (j < 2 * int'(span_e));
	end

	// Rolling update of both strands and the balance
	assign accept   = base_valid & base_ready;
	assign clean    = base_code < BASE_N;
	assign b        = base_code[1:0];
	assign top_sh   = SH_W'({span_e - CFG_W'(1), 1'b0});
	assign fwd_sh   = fwd_q >> top_sh;
	assign leaving  = fwd_sh[1:0];
	assign full_now = fill_q >= span_e;
	assign bal_d    = bal_q + strand_step(b) - (full_now ? strand_step(leaving) : STEP_NONE);
	assign fwd_d    = ((fwd_q << 2) | KW'(b)) & kmask;
	assign rcv_d    = ((rcv_q >> 2) | (KW'(~b) << top_sh)) & kmask;
	assign fill_d   = (fill_q < span_e) ? fill_q + CFG_W'(1) : fill_q;

	// Handshake and request out
	assign base_ready      = ~job_full;
	assign job_push        = accept & clean & (fill_d >= span_e);
	assign job_ctrl.rev    = bal_d >= REV_LIMIT;
	assign job_ctrl.both   = both_strands_q;
	assign job_ctrl.span   = span_e;
	assign job_ctrl.weight = weight_e;
	assign job_fwd         = fwd_d;
	assign job_rcv         = rcv_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_span_q    <= RST_SPAN;
			sub_weight_q   <= RST_WEIGHT;
			both_strands_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPAN:   kmer_span_q    <= cfg_data;
				REG_WEIGHT: sub_weight_q   <= cfg_data;
				REG_BOTH:   both_strands_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// Window state; a span write or an N restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= '0;
			rcv_q  <= '0;
			bal_q  <= STEP_NONE;
			fill_q <= '0;
		end else if (cfg_we && cfg_index == REG_SPAN) begin
			fwd_q  <= '0;
			rcv_q  <= '0;
			bal_q  <= STEP_NONE;
			fill_q <= '0;
		end else if (accept) begin
			if (!clean) begin
				fwd_q  <= '0;
				rcv_q  <= '0;
				bal_q  <= STEP_NONE;
				fill_q <= '0;
			end else begin
				fwd_q  <= fwd_d;
				rcv_q  <= rcv_d;
				bal_q  <= bal_d;
				fill_q <= fill_d;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/ckm_queue.sv
// Short request queue between the front end and the hash back end
`timescale 1ns / 1ps
`default_nettype none
module ckm_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              pop_valid,
	output logic [W-1:0]      pop_data
);
	import ckm_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;

	assign full      = cnt_q == (PW + 1)'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data  = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW + 1)'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/ckm_hash.sv
// One hash lane: four-stage invertible shift/xor/add mix under a width mask
`timescale 1ns / 1ps
`default_nettype none
module ckm_hash #(
	parameter int MAX_SPAN = ckm_pkg::DEF_MAX_SPAN,
	localparam int KW = 2 * MAX_SPAN
) (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic [KW-1:0]                         key,
	input  wire logic [ckm_pkg::HASH_STAGES-1:0][KW-1:0] mask_pipe,
	output logic [KW-1:0]                              hash
);
	import ckm_pkg::*;

	logic [KW-1:0] h_s2;
	logic [KW-1:0] h_s3;
	logic [KW-1:0] h_s4;
	logic [KW-1:0] h_s5;
	logic [KW-1:0] x_b;
	logic [KW-1:0] x_c;
	logic [KW-1:0] x_d;

	// Xor folds ahead of the second, third and fourth add stages
	assign x_b = h_s2 ^ (h_s2 >> 24);
	assign x_c = h_s3 ^ (h_s3 >> 14);
	assign x_d = h_s4 ^ (h_s4 >> 28);

	// Shift and add mix per stage, masked to the sub-k-mer width
	always_ff @(posedge clk) begin
		if (en) begin
			h_s2 <= (~key + (key << 21)) & mask_pipe[0];
			h_s3 <= (x_b + (x_b << 3) + (x_b << 8)) & mask_pipe[1];
			h_s4 <= (x_c + (x_c << 2) + (x_c << 4)) & mask_pipe[2];
			h_s5 <= (x_d + (x_d << 31)) & mask_pipe[3];
		end
	end

	assign hash = h_s5;

endmodule
`default_nettype wire

>>> design/ckm_back.sv
// Back end: sub-k-mer lanes, hash lanes, registered minimum tree, result register
`timescale 1ns / 1ps
`default_nettype none
module ckm_back #(
	parameter int MAX_SPAN = ckm_pkg::DEF_MAX_SPAN,
	localparam int KW = 2 * MAX_SPAN
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	output logic                    job_pop,
	input  wire ckm_pkg::job_ctrl_t job_ctrl,
	input  wire logic [KW-1:0]      job_fwd,
	input  wire logic [KW-1:0]      job_rcv,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic [KW-1:0]           kmer_value,
	output logic [KW-1:0]           minimizer_hash,
	output logic                    reverse_chosen
);
	import ckm_pkg::*;

	localparam int LANES  = 2 * MAX_SPAN;
	localparam int LV     = $clog2(LANES);
	localparam int LEAVES = 1 << LV;
	localparam int DEPTH  = HASH_STAGES + 1 + LV;

	logic                             en;
	logic [KW-1:0]                    chosen;
	logic [KW-1:0]                    src_a;
	logic [KW-1:0]                    wmask;
	logic [LANES-1:0]                 lane_on;
	logic [KW-1:0]                    key_s1 [LANES];
	logic [HASH_STAGES-1:0][KW-1:0]   mask_pipe_q;
	logic [LANES-1:0]                 lane_on_q [HASH_STAGES+1];
	logic [DEPTH-1:0]                 vld_q;
	logic [DEPTH-1:0]                 rev_q;
	logic [KW-1:0]                    kmer_q [DEPTH];
	logic [KW-1:0]                    hash_s5 [LANES];
	logic [KW-1:0]                    leaf [LEAVES];
	logic [KW-1:0]                    node_q [LEAVES-1];
	logic [KW-1:0]                    tree [2*LEAVES-1];

	// Whole pipeline advances unless the result register is held
	assign en      = ~vld_q[DEPTH-1] | result_ready;
	assign job_pop = en & job_valid;

	// Strand selection and lane enables
	assign chosen = job_ctrl.rev ? job_rcv : job_fwd;
	assign src_a  = job_ctrl.both ? job_fwd : chosen;

	always_comb begin
		for (int j = 0; j < KW; j++) wmask[j] = (j < 2 * int'(job_ctrl.weight));
		for (int i = 0; i < MAX_SPAN; i++) begin
			lane_on[i] = (i + int'(job_ctrl.weight) <= int'(job_ctrl.span));
			lane_on[MAX_SPAN + i] = job_ctrl.both &&
				(i + int'(job_ctrl.weight) <= int'(job_ctrl.span));
		end
	end

	// Stage 1: sub-k-mer keys; side data down the pipe
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MAX_SPAN; i++) begin
				key_s1[i]            <= (src_a >> (2 * i)) & wmask;
				key_s1[MAX_SPAN + i] <= (job_rcv >> (2 * i)) & wmask;
			end
			mask_pipe_q[0] <= wmask;
			for (int k = 1; k < HASH_STAGES; k++) mask_pipe_q[k] <= mask_pipe_q[k-1];
			lane_on_q[0] <= lane_on;
			for (int k = 1; k <= HASH_STAGES; k++) lane_on_q[k] <= lane_on_q[k-1];
			kmer_q[0] <= chosen;
			rev_q[0]  <= job_ctrl.rev;
			for (int k = 1; k < DEPTH; k++) begin
				kmer_q[k] <= kmer_q[k-1];
				rev_q[k]  <= rev_q[k-1];
			end
		end
	end

	// Request valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], job_valid};
		end
	end

	// Hash lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		ckm_hash #(
			.MAX_SPAN(MAX_SPAN)
		) u_hash (
			.clk      (clk),
			.en       (en),
			.key      (key_s1[g]),
			.mask_pipe(mask_pipe_q),
			.hash     (hash_s5[g])
		);
	end

	// Leaves: disabled lanes and padding never win
	always_comb begin
		for (int n = 0; n < LANES; n++) leaf[n] = lane_on_q[HASH_STAGES][n] ? hash_s5[n] : '1;
		for (int n = LANES; n < LEAVES; n++) leaf[n] = '1;
	end

	// Heap view of the tree: internal nodes first, leaves after
	always_comb begin
		for (int n = 0; n < LEAVES - 1; n++) tree[n] = node_q[n];
		for (int n = 0; n < LEAVES; n++) tree[LEAVES - 1 + n] = leaf[n];
	end

	// One registered compare per node, one tree level per stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < LEAVES - 1; n++) begin
				node_q[n] <= (tree[2*n+2] < tree[2*n+1]) ? tree[2*n+2] : tree[2*n+1];
			end
		end
	end

	// Result register
	assign result_valid   = vld_q[DEPTH-1];
	assign kmer_value     = kmer_q[DEPTH-1];
	assign reverse_chosen = rev_q[DEPTH-1];
	assign minimizer_hash = node_q[0];

endmodule
`default_nettype wire

>>> design/canonical_kmer_minimizer.sv
// Top level of the canonical k-mer minimizer: front end, request queue, hash back end
// Usage:
//  - Configuration: cfg_we with cfg_index 0 (span), 1 (weight), 2 (both strands) and
//    cfg_data, taken at the clock edge. Writing the span restarts the window.
//  - Input: base_valid/base_ready carry one base_code per request (A, C, G, T; N or
//    codes above restart the window and give no result).
//  - Output: result_valid/result_ready carry kmer_value, minimizer_hash and
//    reverse_chosen, one result per base once span clean bases have been seen.
//  - Throughput: one base per cycle while not stalled; every lane hash and the minimum tree is pipelined.
//  - Pipeline: a taken base is written into a queue slot, then passes one key stage that
//    pops the slot, four hash stages and one stage per level of the minimum tree.
//  - Stall: a held result freezes the back end; the two-entry queue absorbs two more
//    requests, then base_ready drops until the result is taken.
//  - Reset: registers return to span 25, weight 17, single strand; window cleared,
//    queue and pipeline emptied. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module canonical_kmer_minimizer #(
	parameter int MAX_SPAN = ckm_pkg::DEF_MAX_SPAN
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ckm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ckm_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          base_valid,
	output logic                               base_ready,
	input  wire logic [ckm_pkg::BASE_W-1:0]    base_code,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [2*MAX_SPAN-1:0]              kmer_value,
	output logic [2*MAX_SPAN-1:0]              minimizer_hash,
	output logic                               reverse_chosen
);
	import ckm_pkg::*;

	localparam int KW = 2 * MAX_SPAN;
	localparam int JW = $bits(job_ctrl_t) + 2 * KW;

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [JW-1:0] q_wdata;
	logic [JW-1:0] q_rdata;
	job_ctrl_t     f_ctrl;
	job_ctrl_t     b_ctrl;
	logic [KW-1:0] f_fwd;
	logic [KW-1:0] f_rcv;
	logic [KW-1:0] b_fwd;
	logic [KW-1:0] b_rcv;

	// Front end: window and classification
	ckm_front #(
		.MAX_SPAN(MAX_SPAN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.base_valid(base_valid),
		.base_ready(base_ready),
		.base_code (base_code),
		.job_full  (q_full),
		.job_push  (q_push),
		.job_ctrl  (f_ctrl),
		.job_fwd   (f_fwd),
		.job_rcv   (f_rcv)
	);

	// Request queue
	assign q_wdata = {f_ctrl, f_fwd, f_rcv};
	assign {b_ctrl, b_fwd, b_rcv} = q_rdata;

	ckm_queue #(
		.W(JW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_data (q_rdata)
	);

	// Back end: hashing and minimum
	ckm_back #(
		.MAX_SPAN(MAX_SPAN)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (q_valid),
		.job_pop       (q_pop),
		.job_ctrl      (b_ctrl),
		.job_fwd       (b_fwd),
		.job_rcv       (b_rcv),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.kmer_value    (kmer_value),
		.minimizer_hash(minimizer_hash),
		.reverse_chosen(reverse_chosen)
	);

	// Checks
	`ASSERT_NEXT(a_n_restarts, clk, arst_n, base_valid && base_ready && base_code >= BASE_N, !q_push)
	`ASSERT_NEXT(a_span_restarts, clk, arst_n, cfg_we && cfg_index == REG_SPAN, !q_push)
	`ASSERT_IMP(a_pop_nonempty, clk, arst_n, q_pop, q_valid)

endmodule
`default_nettype wire
